### sv/pcee_pkg.sv
// Shared types, constants and helpers for the pin change event encoder.
// No dependencies; imported by every module of the block.
package pcee_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int VOL_W       = 10;
	localparam int PIN_COUNT   = 9;
	localparam int IDX_W       = $clog2(PIN_COUNT);
	localparam int FIFO_DEPTH  = 2;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

	localparam logic [VOL_W-1:0] SAMPLE_MASK = VOL_W'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [VOL_W-1:0] DEADBAND_RESET = 10'd8;
	localparam logic [7:0] VOLUME_HEADER = 8'h13;

	// Port select per pin in visiting order: 1 picks port two, 0 port one.
	localparam logic [PIN_COUNT-1:0] PIN_PORT = 9'b000001011;
	typedef logic [2:0] pin_bit_t;
	localparam pin_bit_t PIN_BIT [PIN_COUNT] = '{
		3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
	};
	typedef logic [7:0] code_t;
	localparam code_t RISE_CODE [PIN_COUNT] = '{
		8'h01, 8'h03, 8'h05, 8'h07, 8'h09, 8'h0B, 8'h0D, 8'h0F, 8'h11
	};
	localparam code_t FALL_CODE [PIN_COUNT] = '{
		8'h02, 8'h04, 8'h06, 8'h08, 8'h0A, 8'h0C, 8'h0E, 8'h10, 8'h12
	};

	// Volume bytes still to send, counted down.
	typedef enum logic [1:0] {
		VOL_NONE = 2'd0,
		VOL_LOW  = 2'd1,
		VOL_HIGH = 2'd2,
		VOL_HDR  = 2'd3
	} vol_step_t;

	typedef struct packed {
		logic [PIN_COUNT-1:0] chg;
		logic [PIN_COUNT-1:0] lvl;
		logic                 vol;
		logic [VOL_W-1:0]     sample;
	} job_t;

	function automatic logic [PIN_COUNT-1:0] watched_pins(input logic [7:0] p1,
			input logic [7:0] p2);
		logic [PIN_COUNT-1:0] r;
		for (int i = 0; i < PIN_COUNT; i++) begin
			r[i] = PIN_PORT[i] ? p2[PIN_BIT[i]] : p1[PIN_BIT[i]];
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] lowest_index(input logic [PIN_COUNT-1:0] m);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = PIN_COUNT - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

### sv/pcee_front.sv
// Front end: accepts snapshots, detects pin edges and volume reports.
// Holds the pin levels, reported volume and deadband. Uses pcee_pkg.
module pcee_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            port_one_pins,
	input  logic [7:0]            port_two_pins,
	input  logic [9:0]            volume_sample,
	input  logic                  cfg_wr_en,
	input  logic [9:0]            cfg_wr_data,
	input  logic                  q_ready,
	output logic                  q_push,
	output pcee_pkg::job_t        q_job
);
	import pcee_pkg::*;

	logic [PIN_COUNT-1:0] levels_q;
	logic [VOL_W-1:0]     reported_q;
	logic [VOL_W-1:0]     deadband_q;

	logic [PIN_COUNT-1:0] now;
	logic [VOL_W-1:0]     sample;
	logic [VOL_W-1:0]     diff;
	logic                 vol;
	logic                 accept;

	always_comb begin
		now    = watched_pins(port_one_pins, port_two_pins);
		sample = volume_sample & SAMPLE_MASK;
		diff   = (sample >= reported_q) ? (sample - reported_q) : (reported_q - sample);
		vol    = diff > deadband_q;
	end

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	assign q_job.chg    = now ^ levels_q;
	assign q_job.lvl    = now;
	assign q_job.vol    = vol;
	assign q_job.sample = sample;
	// quiet inputs produce no job
	assign q_push = accept && (vol || (q_job.chg != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q   <= '0;
			reported_q <= '0;
			deadband_q <= DEADBAND_RESET;
		end else begin
			if (cfg_wr_en) begin
				deadband_q <= cfg_wr_data;
			end
			if (accept) begin
				levels_q <= now;
				if (vol) begin
					reported_q <= sample;
				end
			end
		end
	end

endmodule

### sv/pcee_fifo.sv
// Short job queue between front and back, held in flip-flops.
// Depth from pcee_pkg::FIFO_DEPTH. Uses pcee_pkg.
module pcee_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcee_pkg::job_t push_job,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output pcee_pkg::job_t pop_job
);
	import pcee_pkg::*;

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full  = count_q != CNT_W'(FIFO_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/pcee_back.sv
// Back end: takes jobs from the queue and sends one event byte per cycle while out_ready is high.
// Edge codes first in pin order, then the volume report. Uses pcee_pkg.
module pcee_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  pcee_pkg::job_t q_job,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     event_byte,
	output logic           burst_last
);
	import pcee_pkg::*;

	logic [PIN_COUNT-1:0] rem_q;
	logic [PIN_COUNT-1:0] lvl_q;
	vol_step_t            vstep_q;
	logic [VOL_W-1:0]     sample_q;
	logic                 out_valid_q;
	logic [7:0]           byte_q;
	logic                 last_q;

	logic                 active;
	logic                 take;
	logic [IDX_W-1:0]     idx;
	logic [PIN_COUNT-1:0] rem_next;
	vol_step_t            vstep_next;
	logic [7:0]           byte_d;
	logic                 last_d;

	assign active = (rem_q != '0) || (vstep_q != VOL_NONE);
	assign take   = !out_valid_q || out_ready;

	always_comb begin
		idx        = lowest_index(rem_q);
		rem_next   = rem_q;
		vstep_next = vstep_q;
		byte_d     = '0;
		if (rem_q != '0) begin
			rem_next[idx] = 1'b0;
			byte_d = lvl_q[idx] ? RISE_CODE[idx] : FALL_CODE[idx];
		end else begin
			case (vstep_q)
				VOL_HDR: begin
					byte_d     = VOLUME_HEADER;
					vstep_next = VOL_HIGH;
				end
				VOL_HIGH: begin
					byte_d     = 8'(sample_q >> 8);
					vstep_next = VOL_LOW;
				end
				VOL_LOW: begin
					byte_d     = sample_q[7:0];
					vstep_next = VOL_NONE;
				end
				default: begin
					byte_d     = '0;
					vstep_next = VOL_NONE;
				end
			endcase
		end
		last_d = (rem_next == '0) && (vstep_next == VOL_NONE);
	end

	// fetch the next job while the last byte of the current one goes out
	assign q_pop = take && q_valid && (!active || last_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			vstep_q     <= VOL_NONE;
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= active;
			if (q_pop) begin
				rem_q   <= q_job.chg;
				vstep_q <= q_job.vol ? VOL_HDR : VOL_NONE;
			end else if (active) begin
				rem_q   <= rem_next;
				vstep_q <= vstep_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= byte_d;
			last_q <= last_d;
			if (q_pop) begin
				lvl_q    <= q_job.lvl;
				sample_q <= q_job.sample;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign event_byte = byte_q;
	assign burst_last = last_q;

endmodule

### sv/pin_change_event_encoder_top.sv
// Top level of the pin change event encoder: front, job queue and back.
// Depends on pcee_pkg, pcee_front, pcee_fifo and pcee_back.
//
//   channel | signals                                          | transfer when
//   --------+--------------------------------------------------+----------------------
//   input   | port_one_pins, port_two_pins, volume_sample      | in_valid && in_ready
//   output  | event_byte, burst_last                           | out_valid && out_ready
//   config  | cfg_wr_data (volume deadband)                    | cfg_wr_en
//
// One output byte per cycle while out_ready is high; an input causes 0 to 12 bytes,
// sent through the single byte output register of the back end.
// The front accepts an input per cycle while the two-entry job queue has room.
// An accepted input's job is registered in the job queue, then its first byte in the back end's output register.
// Reset: pin levels low, reported volume 0, deadband 8, queue empty.
module pin_change_event_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] port_one_pins,
	input  logic [7:0] port_two_pins,
	input  logic [9:0] volume_sample,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] event_byte,
	output logic       burst_last,
	input  logic       cfg_wr_en,
	input  logic [9:0] cfg_wr_data
);
	import pcee_pkg::*;

	job_t push_job;
	job_t pop_job;
	logic push;
	logic pop;
	logic not_full;
	logic not_empty;

	pcee_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.port_one_pins (port_one_pins),
		.port_two_pins (port_two_pins),
		.volume_sample (volume_sample),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.q_ready       (not_full),
		.q_push        (push),
		.q_job         (push_job)
	);

	pcee_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_job   (pop_job)
	);

	pcee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (not_empty),
		.q_job      (pop_job),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_byte (event_byte),
		.burst_last (burst_last)
	);

endmodule
